// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Request and result payloads, sequencer states and status codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int unsigned HeapBytesDef   = 1048576;
	localparam int unsigned HeaderBytesDef = 24;
	localparam int unsigned MaxSegmentsDef = 64;
	localparam logic [31:0] HeapBaseReset  = 32'h0100_0000;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [20:0] request_size;
		logic [31:0] release_address;
	} req_t;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [1:0]  status;
		logic [20:0] free_bytes;
		logic [20:0] used_bytes;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPARE,
		S_READ,
		S_EVAL,
		S_SPLIT,
		S_NEXT_RD,
		S_NEXT_EV,
		S_TOT_RD,
		S_TOT_EV,
		S_DONE
	} state_t;

endpackage

// ===== hw/rtl/ffha_table.sv =====
// ----------------------------------------------------------------------------
// ffha_table: segment table storage
// One read port with registered data, one write port, slot-use bits.
// ----------------------------------------------------------------------------
module ffha_table import ffha_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef,
	parameter int unsigned LEN_W        = 21,
	parameter int unsigned OFF_W        = 20,
	parameter int unsigned IDX_W        = 6,
	parameter logic [LEN_W-1:0] LEN0    = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [OFF_W-1:0] rd_off,
	output logic [LEN_W-1:0] rd_len,
	output logic             rd_free,
	output logic [IDX_W:0]   rd_link,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [OFF_W-1:0] wr_off,
	input  logic [LEN_W-1:0] wr_len,
	input  logic             wr_free,
	input  logic [IDX_W:0]   wr_link,
	input  logic             use_set,
	input  logic             use_clr,
	input  logic [IDX_W-1:0] use_idx,
	output logic [MAX_SEGMENTS-1:0] in_use
);

	localparam int unsigned ENT_W = OFF_W + LEN_W + 1 + IDX_W + 1;

	logic [ENT_W-1:0] mem [MAX_SEGMENTS];
	logic [ENT_W-1:0] rd_q;
	logic             rd0_q;
	logic [MAX_SEGMENTS-1:0] used_q;
	logic [IDX_W:0] null_link;

	assign null_link = (IDX_W+1)'(MAX_SEGMENTS);

	// slot 0 reads its reset contents until first written
	logic w0_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_off, wr_len, wr_free, wr_link};
		end
		rd_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= MAX_SEGMENTS'(1);
			w0_q   <= 1'b0;
			rd0_q  <= 1'b0;
		end else begin
			if (use_set) used_q[use_idx] <= 1'b1;
			if (use_clr) used_q[use_idx] <= 1'b0;
			if (wr_en && wr_idx == '0) w0_q <= 1'b1;
			rd0_q <= (rd_idx == '0) && !w0_q;
		end
	end

	always_comb begin
		if (rd0_q) begin
			rd_off  = '0;
			rd_len  = LEN0;
			rd_free = 1'b1;
			rd_link = null_link;
		end else begin
			{rd_off, rd_len, rd_free, rd_link} = rd_q;
		end
	end

	assign in_use = used_q;

endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: sequenced first-fit heap allocator
// Segment chain walker over a segment table with one read and one write port.
// ----------------------------------------------------------------------------
// One request is in flight at a time; ready is low while it runs. An
// allocate walks the address-ordered chain, a table read and then a fit
// compare per segment, splits on a fit when a spare slot is free and the
// remainder exceeds a header, then walks the chain again to total free and
// used bytes; a release walks to the matching payload address, merges with
// a free successor, then totals. Each segment visited takes a read of the
// single read port of the segment table. Finding a spare slot for a split
// is a priority scan of the slot-use bits, done once per request. The
// result sits in an output register; a new request is taken once it leaves.
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int unsigned HEAP_BYTES   = HeapBytesDef,
	parameter int unsigned HEADER_BYTES = HeaderBytesDef,
	parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        out_data,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
	localparam int unsigned LEN_W = 21;
	localparam int unsigned OFF_W = 20;
	localparam logic [LEN_W-1:0] HDR  = LEN_W'(HEADER_BYTES);
	localparam logic [LEN_W-1:0] LEN0 = LEN_W'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [IDX_W:0]   NULL_L = (IDX_W+1)'(MAX_SEGMENTS);
	localparam logic [IDX_W:0]   MAX_N  = (IDX_W+1)'(MAX_SEGMENTS);

	state_t state_q, state_d;
	logic [31:0] base_q;
	logic started_q;
	req_t req_q;
	rsp_t rsp_q;
	logic [IDX_W-1:0] cur_q, spare_q;
	logic spare_ok_q;
	logic [IDX_W:0] cnt_q;
	logic [OFF_W-1:0] off_q;
	logic [LEN_W-1:0] len_q;
	logic [IDX_W:0] link_q;
	logic [LEN_W-1:0] fr_q, us_q;
	logic [31:0] addr_q;
	logic [1:0] st_q;

	logic [IDX_W-1:0] rd_idx;
	logic [OFF_W-1:0] rd_off;
	logic [LEN_W-1:0] rd_len;
	logic rd_free;
	logic [IDX_W:0] rd_link;
	logic wr_en, wr_free, use_set, use_clr;
	logic [IDX_W-1:0] wr_idx, use_idx;
	logic [OFF_W-1:0] wr_off;
	logic [LEN_W-1:0] wr_len;
	logic [IDX_W:0] wr_link;
	logic [MAX_SEGMENTS-1:0] in_use;

	ffha_table #(
		.MAX_SEGMENTS(MAX_SEGMENTS), .LEN_W(LEN_W), .OFF_W(OFF_W),
		.IDX_W(IDX_W), .LEN0(LEN0)
	) u_table (
		.clk, .arst_n, .rd_idx, .rd_off, .rd_len, .rd_free, .rd_link,
		.wr_en, .wr_idx, .wr_off, .wr_len, .wr_free, .wr_link,
		.use_set, .use_clr, .use_idx, .in_use
	);

	// spare slot search: lowest clear slot-use bit
	logic [IDX_W-1:0] spare_d;
	logic spare_any;
	always_comb begin
		spare_d = '0;
		spare_any = 1'b0;
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
			if (!in_use[i]) begin
				spare_d = IDX_W'(i);
				spare_any = 1'b1;
			end
		end
	end

	// shared arithmetic: payload address, fit compare, split remainder
	logic [31:0] pay_addr;
	logic [LEN_W:0] need;
	logic fits, splits;
	logic cur_valid;
	logic [LEN_W-1:0] acc_sum;
	assign pay_addr = base_q + 32'(rd_off) + 32'(HDR);
	assign need     = {1'b0, req_q.request_size} + {1'b0, HDR};
	assign fits     = rd_free && (rd_len >= req_q.request_size);
	assign splits   = ({1'b0, rd_len} > need) && spare_ok_q;
	assign cur_valid = in_use[cur_q] && (cnt_q < MAX_N);
	assign acc_sum  = (rd_free ? fr_q : us_q) + rd_len;

	logic nxt_valid;
	assign nxt_valid = (link_q < NULL_L) && in_use[link_q[IDX_W-1:0]];

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		state_d = state_q;
		rd_idx  = cur_q;
		wr_en   = 1'b0;
		wr_idx  = cur_q;
		wr_off  = rd_off;
		wr_len  = rd_len;
		wr_free = rd_free;
		wr_link = rd_link;
		use_set = 1'b0;
		use_clr = 1'b0;
		use_idx = cur_q;
		unique case (state_q)
			S_IDLE:    if (in_valid && in_ready) state_d = S_SPARE;
			S_SPARE: begin
				if (req_q.mode == MODE_RELEASE &&
				    (req_q.release_address == '0 || !started_q))
					state_d = S_DONE;
				else
					state_d = S_READ;
			end
			S_READ:    state_d = cur_valid ? S_EVAL : (started_q ? S_TOT_RD : S_DONE);
			S_EVAL: begin
				if (req_q.mode == MODE_ALLOC) begin
					if (fits) begin
						wr_en   = 1'b1;
						wr_free = 1'b0;
						if (splits) begin
							wr_len  = req_q.request_size;
							wr_link = {1'b0, spare_q};
							state_d = S_SPLIT;
						end else begin
							state_d = S_TOT_RD;
						end
					end else begin
						state_d = S_READ;
					end
				end else begin
					if (pay_addr == req_q.release_address) state_d = S_NEXT_RD;
					else state_d = S_READ;
				end
			end
			S_SPLIT: begin
				wr_en   = 1'b1;
				wr_idx  = spare_q;
				wr_off  = off_q + OFF_W'(HDR) + OFF_W'(req_q.request_size);
				wr_len  = len_q - req_q.request_size - HDR;
				wr_free = 1'b1;
				wr_link = link_q;
				use_set = 1'b1;
				use_idx = spare_q;
				state_d = S_TOT_RD;
			end
			S_NEXT_RD: begin
				rd_idx = link_q[IDX_W-1:0];
				state_d = S_NEXT_EV;
			end
			S_NEXT_EV: begin
				wr_en   = 1'b1;
				wr_off  = off_q;
				wr_free = 1'b1;
				if (nxt_valid && rd_free) begin
					wr_len  = len_q + HDR + rd_len;
					wr_link = rd_link;
					use_clr = 1'b1;
					use_idx = link_q[IDX_W-1:0];
				end else begin
					wr_len  = len_q;
					wr_link = link_q;
				end
				state_d = S_TOT_RD;
			end
			S_TOT_RD:  state_d = cur_valid ? S_TOT_EV : S_DONE;
			S_TOT_EV:  state_d = S_TOT_RD;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			base_q    <= HeapBaseReset;
			started_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) base_q <= cfg_wdata;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (state_q == S_SPARE && req_q.mode == MODE_ALLOC) started_q <= 1'b1;
			if (state_q == S_DONE) out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) req_q <= in_data;
			S_SPARE: begin
				spare_q    <= spare_d;
				spare_ok_q <= spare_any;
				cur_q      <= '0;
				cnt_q      <= '0;
				addr_q     <= '0;
				st_q       <= (req_q.mode == MODE_ALLOC) ? ST_NO_FIT : ST_BAD;
			end
			S_EVAL: begin
				off_q  <= rd_off;
				len_q  <= rd_len;
				link_q <= rd_link;
				if (req_q.mode == MODE_ALLOC) begin
					if (fits) begin
						st_q   <= ST_OK;
						addr_q <= pay_addr;
					end
				end else if (pay_addr == req_q.release_address) begin
					st_q <= ST_OK;
				end
				// hold the matched slot for a release; advance only on a miss,
				// and stop the walk at a null link
				if (state_d == S_TOT_RD) begin
					cur_q <= '0;
					cnt_q <= '0;
					fr_q  <= '0;
					us_q  <= '0;
				end else if (state_d == S_READ) begin
					cnt_q <= (rd_link >= NULL_L) ? MAX_N : cnt_q + 1'b1;
					cur_q <= rd_link[IDX_W-1:0];
				end
			end
			S_SPLIT: begin
				cur_q <= '0;
				cnt_q <= '0;
				fr_q  <= '0;
				us_q  <= '0;
			end
			S_READ: begin
				if (!cur_valid) begin
					cur_q <= '0;
					cnt_q <= '0;
					fr_q  <= '0;
					us_q  <= '0;
				end
			end
			S_NEXT_EV: begin
				cur_q <= '0;
				cnt_q <= '0;
				fr_q  <= '0;
				us_q  <= '0;
			end
			S_TOT_EV: begin
				if (rd_free) fr_q <= acc_sum;
				else us_q <= acc_sum;
				cnt_q <= (rd_link >= NULL_L) ? MAX_N : cnt_q + 1'b1;
				cur_q <= rd_link[IDX_W-1:0];
			end
			S_DONE: begin
				rsp_q.granted_address <= addr_q;
				rsp_q.status          <= st_q;
				rsp_q.free_bytes      <= started_q ? fr_q : LEN_W'(HEAP_BYTES);
				rsp_q.used_bytes      <= started_q ? us_q : '0;
			end
			default: ;
		endcase
	end

	assign out_data = rsp_q;

	// a new request is only taken with the sequencer idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (state_q == S_IDLE && !out_valid))
		else $error("request accepted while busy");
	// a result leaves only after the done step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside done step");
	// release never hands out an address
	a_rel_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && req_q.mode == MODE_RELEASE) |-> out_data.granted_address == '0)
		else $error("release returned an address");

endmodule
